// File: rtl/lrukv_pkg.sv
// lrukv_pkg: types and constants shared by the lru key-value cache modules
// holds the controller state type, the command and status structs and field widths
// no dependencies
package lrukv_pkg;

   localparam int unsigned KEY_W   = 32;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned CAP_W   = 5;

   localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
   localparam logic               OP_GET    = 1'b0;
   localparam logic               OP_PUT    = 1'b1;
   localparam logic [VALUE_W-1:0] READ_MISS = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } lrukv_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture the request beat, restart the walk
      logic scan;    // walk the key store one entry a cycle
      logic commit;  // apply the update and load the response register
   } lrukv_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;  // every entry has been compared
      logic out_free;   // response register can take a beat this cycle
   } lrukv_status_type;

endpackage

// File: rtl/lrukv_ram.sv
// lrukv_ram: generic single write port, single read port ram with registered read
// no dependencies
module lrukv_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/lrukv_ctrl.sv
// lrukv_ctrl: sequencing state machine of the lru key-value cache
// depends on lrukv_pkg for the state, command and status types
module lrukv_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  lrukv_pkg::lrukv_status_type status,
   output lrukv_pkg::lrukv_cmd_type    cmd
);

   lrukv_pkg::lrukv_state_type state_ff;
   lrukv_pkg::lrukv_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrukv_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lrukv_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = lrukv_pkg::ST_SCAN;
            end
         end
         lrukv_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = lrukv_pkg::ST_COMMIT;
            end
         end
         lrukv_pkg::ST_COMMIT: begin
            if (status.out_free) begin
               state_in = lrukv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lrukv_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         lrukv_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         lrukv_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         lrukv_pkg::ST_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

`ifndef SYNTH
   // a walk only starts from an accepted beat
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == lrukv_pkg::ST_SCAN && $past(state_ff) == lrukv_pkg::ST_IDLE)
      |-> $past(req_tvalid))
      else $error("walk started without an accepted request beat");
`endif

endmodule

// File: rtl/lrukv_datapath.sv
// lrukv_datapath: key and value stores, valid bits, recency ranks and response register
// depends on lrukv_pkg and lrukv_ram
module lrukv_datapath #(
   parameter int unsigned MAX_ENTRIES = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lrukv_pkg::lrukv_cmd_type             cmd,
   output lrukv_pkg::lrukv_status_type          status,
   input  logic                                 req_opcode,
   input  logic signed [lrukv_pkg::KEY_W-1:0]   req_key,
   input  logic signed [lrukv_pkg::VALUE_W-1:0] req_value,
   input  logic                                 csr_wr_en,
   input  logic [lrukv_pkg::CAP_W-1:0]          csr_wr_data,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic                                 rsp_found,
   output logic signed [lrukv_pkg::VALUE_W-1:0] rsp_read_value,
   output logic                                 rsp_evicted
);

   localparam int unsigned IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned RW   = IW;
   localparam int unsigned CMPW = (CW > lrukv_pkg::CAP_W) ? CW : lrukv_pkg::CAP_W;

   // configuration
   logic [lrukv_pkg::CAP_W-1:0] capacity_ff;

   // request beat held for the whole access
   logic                                 op_ff;
   logic signed [lrukv_pkg::KEY_W-1:0]   key_ff;
   logic signed [lrukv_pkg::VALUE_W-1:0] value_ff;

   // entry state
   logic [MAX_ENTRIES-1:0] entry_valid_ff;
   logic [MAX_ENTRIES-1:0] entry_valid_in;
   logic [RW-1:0] rank_ff        [MAX_ENTRIES];
   logic [RW-1:0] rank_in        [MAX_ENTRIES];
   logic [CW-1:0] used_ff;
   logic [CW-1:0] used_in;

   // walk over the entries
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic          probe_live_ff;
   logic          probe_live_in;
   logic [IW-1:0] probe_idx_ff;
   logic          issue;

   // walk findings
   logic                                 hit_found_ff;
   logic                                 hit_found_in;
   logic [IW-1:0]                        hit_idx_ff;
   logic [IW-1:0]                        hit_idx_in;
   logic [RW-1:0]                        hit_rank_ff;
   logic [RW-1:0]                        hit_rank_in;
   logic signed [lrukv_pkg::VALUE_W-1:0] hit_value_ff;
   logic signed [lrukv_pkg::VALUE_W-1:0] hit_value_in;
   logic                                 victim_found_ff;
   logic                                 victim_found_in;
   logic [IW-1:0]                        victim_idx_ff;
   logic [IW-1:0]                        victim_idx_in;
   logic                                 free_found_ff;
   logic                                 free_found_in;
   logic [IW-1:0]                        free_idx_ff;
   logic [IW-1:0]                        free_idx_in;

   // store ports
   logic [lrukv_pkg::KEY_W-1:0]   key_rd;
   logic [lrukv_pkg::VALUE_W-1:0] val_rd;
   logic                          key_we;
   logic                          val_we;
   logic [IW-1:0]                 wr_addr;

   // commit decisions
   logic [CMPW-1:0] cap_eff;
   logic            need_evict;
   logic            evict_now;
   logic [IW-1:0]   slot_idx;
   logic            slot_ok;

   // response register
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic                                 rsp_found_ff;
   logic                                 rsp_found_in;
   logic signed [lrukv_pkg::VALUE_W-1:0] rsp_value_ff;
   logic signed [lrukv_pkg::VALUE_W-1:0] rsp_value_in;
   logic                                 rsp_evicted_ff;
   logic                                 rsp_evicted_in;

   assign issue = cmd.scan && (cnt_ff < CW'(MAX_ENTRIES));

   lrukv_ram #(
      .WIDTH (lrukv_pkg::KEY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (wr_addr),
      .wr_data (key_ff),
      .rd_en   (issue),
      .rd_addr (cnt_ff[IW-1:0]),
      .rd_data (key_rd)
   );

   lrukv_ram #(
      .WIDTH (lrukv_pkg::VALUE_W),
      .DEPTH (MAX_ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_en   (issue),
      .rd_addr (cnt_ff[IW-1:0]),
      .rd_data (val_rd)
   );

   // walk: address goes out one cycle, the compare follows the next
   always_comb begin
      cnt_in          = cnt_ff;
      probe_live_in   = issue;
      hit_found_in    = hit_found_ff;
      hit_idx_in      = hit_idx_ff;
      hit_rank_in     = hit_rank_ff;
      hit_value_in    = hit_value_ff;
      victim_found_in = victim_found_ff;
      victim_idx_in   = victim_idx_ff;
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      if (cmd.load) begin
         cnt_in          = '0;
         hit_found_in    = 1'b0;
         victim_found_in = 1'b0;
         free_found_in   = 1'b0;
      end else begin
         if (issue) begin
            cnt_in = cnt_ff + CW'(1);
         end
         if (probe_live_ff) begin
            if (entry_valid_ff[probe_idx_ff]) begin
               if (!hit_found_ff && key_rd == key_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = probe_idx_ff;
                  hit_rank_in  = rank_ff[probe_idx_ff];
                  hit_value_in = val_rd;
               end
               // oldest entry holds the top rank
               if (!victim_found_ff && CW'(rank_ff[probe_idx_ff]) == used_ff - CW'(1)) begin
                  victim_found_in = 1'b1;
                  victim_idx_in   = probe_idx_ff;
               end
            end else if (!free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = probe_idx_ff;
            end
         end
      end
   end

   // commit decisions
   always_comb begin
      cap_eff = CMPW'(capacity_ff);
      priority if (capacity_ff == '0) begin
         cap_eff = CMPW'(1);
      end else if (CMPW'(capacity_ff) > CMPW'(MAX_ENTRIES)) begin
         cap_eff = CMPW'(MAX_ENTRIES);
      end
      need_evict = (used_ff != '0) && (CMPW'(used_ff) >= cap_eff);
      evict_now  = need_evict && victim_found_ff;
      if (evict_now) begin
         slot_idx = (free_found_ff && free_idx_ff < victim_idx_ff) ? free_idx_ff : victim_idx_ff;
      end else begin
         slot_idx = free_idx_ff;
      end
      slot_ok = evict_now || free_found_ff;
   end

   // entry update and response
   always_comb begin
      entry_valid_in = entry_valid_ff;
      rank_in        = rank_ff;
      used_in        = used_ff;
      key_we         = 1'b0;
      val_we         = 1'b0;
      wr_addr        = slot_idx;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_found_in   = rsp_found_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_evicted_in = rsp_evicted_ff;
      if (cmd.commit) begin
         rsp_valid_in   = 1'b1;
         rsp_found_in   = hit_found_ff;
         rsp_value_in   = '0;
         rsp_evicted_in = 1'b0;
         if (hit_found_ff) begin
            // move the hit entry to the front, younger entries age by one
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (entry_valid_ff[i] && IW'(i) != hit_idx_ff && rank_ff[i] < hit_rank_ff) begin
                  rank_in[i] = rank_ff[i] + RW'(1);
               end
            end
            rank_in[hit_idx_ff] = '0;
            if (op_ff == lrukv_pkg::OP_GET) begin
               rsp_value_in = hit_value_ff;
            end else begin
               val_we  = 1'b1;
               wr_addr = hit_idx_ff;
            end
         end else if (op_ff == lrukv_pkg::OP_GET) begin
            rsp_value_in = lrukv_pkg::READ_MISS;
         end else if (slot_ok) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (entry_valid_ff[i] && !(evict_now && IW'(i) == victim_idx_ff)) begin
                  rank_in[i] = rank_ff[i] + RW'(1);
               end
            end
            if (evict_now) begin
               entry_valid_in[victim_idx_ff] = 1'b0;
            end
            entry_valid_in[slot_idx] = 1'b1;
            rank_in[slot_idx]        = '0;
            used_in                  = evict_now ? used_ff : used_ff + CW'(1);
            key_we                   = 1'b1;
            val_we                   = 1'b1;
            rsp_evicted_in           = evict_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff     <= lrukv_pkg::CAP_RESET;
         used_ff         <= '0;
         cnt_ff          <= '0;
         probe_live_ff   <= 1'b0;
         hit_found_ff    <= 1'b0;
         victim_found_ff <= 1'b0;
         free_found_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            entry_valid_ff[i] <= 1'b0;
            rank_ff[i]        <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         used_ff         <= used_in;
         cnt_ff          <= cnt_in;
         probe_live_ff   <= probe_live_in;
         hit_found_ff    <= hit_found_in;
         victim_found_ff <= victim_found_in;
         free_found_ff   <= free_found_in;
         rsp_valid_ff    <= rsp_valid_in;
         entry_valid_ff  <= entry_valid_in;
         rank_ff         <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      probe_idx_ff   <= cnt_ff[IW-1:0];
      hit_idx_ff     <= hit_idx_in;
      hit_rank_ff    <= hit_rank_in;
      hit_value_ff   <= hit_value_in;
      victim_idx_ff  <= victim_idx_in;
      free_idx_ff    <= free_idx_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_evicted_ff <= rsp_evicted_in;
   end

   assign status.scan_done = (cnt_ff == CW'(MAX_ENTRIES)) && !probe_live_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

`ifndef SYNTH
   // occupancy count tracks the valid bits
   assert property (@(posedge clock) disable iff (reset)
      $countones(entry_valid_ff) == int'(used_ff))
      else $error("occupancy count disagrees with valid bits");

   // a full cache always yields an oldest entry to evict
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && op_ff == lrukv_pkg::OP_PUT && !hit_found_ff && need_evict)
      |-> victim_found_ff)
      else $error("no oldest entry found for eviction");

   // a pending response is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_value_ff)))
      else $error("pending response beat lost or altered");
`endif

endmodule

// File: rtl/lru_key_value_cache.sv
// lru_key_value_cache: top level of the fully associative key-value cache
// instantiates lrukv_ctrl and lrukv_datapath, uses lrukv_pkg
//
// Fully associative key-value cache with least-recently-used replacement for up to
// MAX_ENTRIES entries. Each request beat is a get (tuser 0) or a put (tuser 1) of a
// 32-bit key and value; every request gives exactly one response beat carrying found,
// evicted and the read value (stored value on a get hit, -1 on a get miss, 0 on a put).
// One request is handled at a time: the beat is accepted, the key store is walked
// through its single read port (one address a cycle, then the registered read of the
// last entry and its compare settle), and the update is committed.
// A finished response waits in an output register while the next request is taken;
// the commit of that next request stalls until the waiting beat has gone.
// Recency is kept as a rank per entry in flip-flops, 0 being the most recent; valid
// bits clear on reset, so no clearing pass is needed. csr_wr_data sets the capacity
// that triggers eviction: 0 acts as 1 and values above MAX_ENTRIES act as MAX_ENTRIES.
// Write the capacity only while no request is in flight.
module lru_key_value_cache #(
   parameter int unsigned MAX_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request beat
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // [31:0] key, [63:32] value
   input  logic        req_tuser,  // [0] opcode
   // response beat
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] read_value
   output logic [1:0]  rsp_tuser,  // [0] found, [1] evicted
   // capacity register
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);

   lrukv_pkg::lrukv_cmd_type    cmd;
   lrukv_pkg::lrukv_status_type status;

   logic                                 rsp_found;
   logic                                 rsp_evicted;
   logic signed [lrukv_pkg::VALUE_W-1:0] rsp_read_value;

   // sequencing: idle, walk, commit
   lrukv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // stores, ranks and response register
   lrukv_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_tuser),
      .req_key        (req_tdata[31:0]),
      .req_value      (req_tdata[63:32]),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_read_value),
      .rsp_evicted    (rsp_evicted)
   );

   // pack the response beat
   assign rsp_tdata = rsp_read_value;
   assign rsp_tuser = {rsp_evicted, rsp_found};

endmodule
